### rtl/igr_pkg.sv
// ----------------------------------------------------------------------------
// igr_pkg: shared types and constants of the IGMP report scheduler
// Holds the command and result word layouts, message codes and status codes.
// ----------------------------------------------------------------------------
package igr_pkg;

	// Input word: one command to the scheduler.
	typedef struct packed {
		logic [1:0]  mode;
		logic [7:0]  msg_type;
		logic [7:0]  max_resp_time;
		logic [31:0] group_addr;
	} in_word_t;

	// Output word: a report or a status result.
	typedef struct packed {
		logic        is_report;
		logic [31:0] report_group;
		logic [7:0]  report_type;
		logic [2:0]  status;
		logic        last;
	} out_word_t;

	// Configuration seen by the table walker.
	typedef struct packed {
		logic        rand_en;
		logic        seed_load;
		logic [31:0] seed_val;
	} cfg_t;

	localparam logic [1:0] MODE_MSG   = 2'd0;
	localparam logic [1:0] MODE_TICK  = 2'd1;
	localparam logic [1:0] MODE_JOIN  = 2'd2;
	localparam logic [1:0] MODE_LEAVE = 2'd3;

	localparam logic [7:0] TYPE_QUERY     = 8'h11;
	localparam logic [7:0] TYPE_REPORT_V2 = 8'h16;
	localparam logic [2:0] JOIN_MASK      = 3'h7;
	localparam logic [31:0] LFSR_TAPS     = 32'h8020_0003;

	localparam logic [2:0] ST_ADDED   = 3'd0;
	localparam logic [2:0] ST_DUP     = 3'd1;
	localparam logic [2:0] ST_REMOVED = 3'd2;
	localparam logic [2:0] ST_DECR    = 3'd3;
	localparam logic [2:0] ST_NOTFND  = 3'd4;
	localparam logic [2:0] ST_FULL    = 3'd5;
	localparam logic [2:0] ST_QUERY   = 3'd6;
	localparam logic [2:0] ST_OTHER   = 3'd7;

	// Most reports sent for one tick.
	localparam int MAX_RESULTS = 16;
	localparam int RES_CNT_W   = 5;

	// Entry layout in the table memory: group, countdown, socket count.
	localparam int ENTRY_W = 48;

	// Register indexes of the configuration port.
	localparam logic REG_RAND_EN = 1'b0;
	localparam logic REG_SEED    = 1'b1;

endpackage

### rtl/igr_ram.sv
// ----------------------------------------------------------------------------
// igr_ram: generic single-write, single-read memory
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module igr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/igr_walker.sv
// ----------------------------------------------------------------------------
// igr_walker: group table sequencer
// Walks the group table memory slot by slot for ticks, queries, joins and
// leaves, keeps the valid bits and the random generator, and drives results.
// ----------------------------------------------------------------------------
module igr_walker #(
	parameter int DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  igr_pkg::cfg_t      cfg,
	input  logic               start,
	input  igr_pkg::in_word_t  cmd,
	output logic               busy,
	output logic               res_strobe,
	output igr_pkg::out_word_t res
);

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_READ = 2'd1;
	localparam logic [1:0] S_PROC = 2'd2;
	localparam logic [1:0] S_FIN  = 2'd3;

	logic [1:0]  state_q;
	logic [1:0]  mode_q;
	logic [31:0] grp_q;
	logic [7:0]  mrt_q;
	logic [7:0]  m_q;
	logic [7:0]  mask_q;
	logic [7:0]  cnt_q;
	logic [IDX_W-1:0] slot_q;
	logic [igr_pkg::RES_CNT_W-1:0] n_q;
	logic        pend_v_q;
	logic [31:0] pend_grp_q;
	logic        done_q;
	logic [2:0]  status_q;
	logic [DEPTH-1:0] valid_q;
	logic [31:0] lfsr_q;
	logic        res_strobe_q;
	igr_pkg::out_word_t res_q;

	logic [31:0] lfsr_next;
	logic [igr_pkg::ENTRY_W-1:0] rdata;
	logic [31:0] rd_grp;
	logic [7:0]  rd_cd;
	logic [7:0]  rd_sk;
	logic        rd_v;
	logic [7:0]  m_new;
	logic [7:0]  smear;
	logic [7:0]  qr_raw;
	logic [7:0]  qr;
	logic        free_found;
	logic [IDX_W-1:0] free_idx;
	logic        we;
	logic [IDX_W-1:0] waddr;
	logic [igr_pkg::ENTRY_W-1:0] wdata;
	logic        last_slot;

	// Random generator step: Galois form, right shift.
	assign lfsr_next = {1'b0, lfsr_q[31:1]} ^ (lfsr_q[0] ? igr_pkg::LFSR_TAPS : 32'd0);

	// Fields of the entry read in the previous cycle.
	assign rd_grp = rdata[47:16];
	assign rd_cd  = rdata[15:8];
	assign rd_sk  = rdata[7:0];
	assign rd_v   = valid_q[slot_q];
	assign last_slot = (slot_q == IDX_W'(DEPTH - 1));

	// Query range and its smeared mask, from the incoming word.
	always_comb begin
		m_new = ((cmd.max_resp_time < 8'd2) ? 8'd2 : cmd.max_resp_time) - 8'd1;
		smear = m_new - 8'd1;
		smear = smear | (smear >> 1);
		smear = smear | (smear >> 2);
		smear = smear | (smear >> 4);
		if (smear == 8'd0) begin
			smear = 8'd1;
		end
	end

	// Random countdown for a query: the mask keeps it below twice the range.
	always_comb begin
		qr_raw = lfsr_next[7:0] & mask_q;
		if (qr_raw == 8'd0) begin
			qr_raw = 8'd1;
		end
		qr = (qr_raw > m_q) ? qr_raw - m_q : qr_raw;
		if (!cfg.rand_en) begin
			qr = cnt_q;
		end
	end

	// First free slot from the valid bits.
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_found = 1'b1;
				free_idx   = IDX_W'(i);
			end
		end
	end

	// Write port of the table memory.
	always_comb begin
		we    = 1'b0;
		waddr = slot_q;
		wdata = rdata;
		if (state_q == S_PROC && rd_v) begin
			case (mode_q)
				igr_pkg::MODE_TICK: begin
					if (rd_cd != 8'd0) begin
						we    = 1'b1;
						wdata = {rd_grp, rd_cd - 8'd1, rd_sk};
					end
				end
				igr_pkg::MODE_MSG: begin
					if (rd_cd == 8'd0 || rd_cd >= mrt_q) begin
						we    = 1'b1;
						wdata = {rd_grp, qr, rd_sk};
					end
				end
				igr_pkg::MODE_JOIN: begin
					if (rd_grp == grp_q) begin
						we    = 1'b1;
						wdata = {rd_grp, rd_cd, (rd_sk == 8'hFF) ? rd_sk : rd_sk + 8'd1};
					end
				end
				default: begin
					if (rd_grp == grp_q) begin
						we    = 1'b1;
						wdata = {rd_grp, rd_cd, (rd_sk != 8'd0) ? rd_sk - 8'd1 : rd_sk};
					end
				end
			endcase
		end else if (state_q == S_FIN && mode_q == igr_pkg::MODE_JOIN && !done_q &&
			free_found) begin
			we    = 1'b1;
			waddr = free_idx;
			wdata = {grp_q,
				8'd2 + {5'd0, (cfg.rand_en ? lfsr_next[2:0] : 3'(free_idx)) &
					igr_pkg::JOIN_MASK},
				8'd1};
		end
	end

	igr_ram #(
		.WIDTH (igr_pkg::ENTRY_W),
		.DEPTH (DEPTH)
	) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (state_q == S_READ),
		.raddr (slot_q),
		.rdata (rdata)
	);

	// Sequencer, valid bits, random generator and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			mode_q       <= igr_pkg::MODE_MSG;
			grp_q        <= '0;
			mrt_q        <= '0;
			m_q          <= '0;
			mask_q       <= '0;
			cnt_q        <= 8'd1;
			slot_q       <= '0;
			n_q          <= '0;
			pend_v_q     <= 1'b0;
			pend_grp_q   <= '0;
			done_q       <= 1'b0;
			status_q     <= igr_pkg::ST_OTHER;
			valid_q      <= '0;
			lfsr_q       <= 32'd1;
			res_strobe_q <= 1'b0;
			res_q        <= '0;
		end else begin
			res_strobe_q <= 1'b0;
			if (cfg.seed_load) begin
				lfsr_q <= (cfg.seed_val != 32'd0) ? cfg.seed_val : 32'd1;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						mode_q   <= cmd.mode;
						grp_q    <= cmd.group_addr;
						mrt_q    <= cmd.max_resp_time;
						m_q      <= m_new;
						mask_q   <= smear;
						cnt_q    <= 8'd1;
						slot_q   <= '0;
						n_q      <= '0;
						pend_v_q <= 1'b0;
						done_q   <= 1'b0;
						if (cmd.mode == igr_pkg::MODE_MSG &&
							(cmd.msg_type != igr_pkg::TYPE_QUERY ||
							cmd.group_addr != 32'd0)) begin
							// Nothing to walk: answer at once.
							res_strobe_q <= 1'b1;
							res_q        <= '{1'b0, 32'd0, 8'd0,
								(cmd.msg_type == igr_pkg::TYPE_QUERY) ?
								igr_pkg::ST_QUERY : igr_pkg::ST_OTHER, 1'b1};
						end else begin
							state_q <= S_READ;
						end
					end
				end
				S_READ: begin
					state_q <= S_PROC;
				end
				S_PROC: begin
					state_q <= last_slot ? S_FIN : S_READ;
					slot_q  <= slot_q + IDX_W'(1);
					case (mode_q)
						igr_pkg::MODE_TICK: begin
							if (rd_v && rd_cd == 8'd1) begin
								// Expiry: send the one held back, hold this one.
								if (pend_v_q) begin
									res_strobe_q <= 1'b1;
									res_q <= '{1'b1, pend_grp_q, igr_pkg::TYPE_REPORT_V2,
										igr_pkg::ST_OTHER, 1'b0};
								end
								pend_v_q   <= 1'b1;
								pend_grp_q <= rd_grp;
								n_q        <= n_q + igr_pkg::RES_CNT_W'(1);
								if (n_q == igr_pkg::RES_CNT_W'(igr_pkg::MAX_RESULTS - 1)) begin
									state_q <= S_FIN;
								end
							end
						end
						igr_pkg::MODE_MSG: begin
							if (rd_v && (rd_cd == 8'd0 || rd_cd >= mrt_q)) begin
								if (cfg.rand_en) begin
									lfsr_q <= lfsr_next;
								end else begin
									cnt_q <= (cnt_q >= m_q) ? 8'd1 : cnt_q + 8'd1;
								end
							end
						end
						igr_pkg::MODE_JOIN: begin
							if (rd_v && rd_grp == grp_q) begin
								done_q   <= 1'b1;
								status_q <= igr_pkg::ST_DUP;
								state_q  <= S_FIN;
							end
						end
						default: begin
							if (rd_v && rd_grp == grp_q) begin
								done_q  <= 1'b1;
								state_q <= S_FIN;
								if (rd_sk <= 8'd1) begin
									valid_q[slot_q] <= 1'b0;
									status_q        <= igr_pkg::ST_REMOVED;
								end else begin
									status_q <= igr_pkg::ST_DECR;
								end
							end
						end
					endcase
				end
				default: begin
					// Closing step: final result of the command.
					state_q <= S_IDLE;
					case (mode_q)
						igr_pkg::MODE_TICK: begin
							if (pend_v_q) begin
								res_strobe_q <= 1'b1;
								res_q <= '{1'b1, pend_grp_q, igr_pkg::TYPE_REPORT_V2,
									igr_pkg::ST_OTHER, 1'b1};
							end
						end
						igr_pkg::MODE_MSG: begin
							res_strobe_q <= 1'b1;
							res_q <= '{1'b0, 32'd0, 8'd0, igr_pkg::ST_QUERY, 1'b1};
						end
						igr_pkg::MODE_JOIN: begin
							res_strobe_q <= 1'b1;
							if (done_q) begin
								res_q <= '{1'b0, 32'd0, 8'd0, status_q, 1'b1};
							end else if (free_found) begin
								valid_q[free_idx] <= 1'b1;
								if (cfg.rand_en) begin
									lfsr_q <= lfsr_next;
								end
								res_q <= '{1'b0, 32'd0, 8'd0, igr_pkg::ST_ADDED, 1'b1};
							end else begin
								res_q <= '{1'b0, 32'd0, 8'd0, igr_pkg::ST_FULL, 1'b1};
							end
						end
						default: begin
							res_strobe_q <= 1'b1;
							res_q <= '{1'b0, 32'd0, 8'd0,
								done_q ? status_q : igr_pkg::ST_NOTFND, 1'b1};
						end
					endcase
				end
			endcase
		end
	end

	assign busy       = (state_q != S_IDLE);
	assign res_strobe = res_strobe_q;
	assign res        = res_q;

endmodule

### rtl/igmp_report_scheduler.sv
// ----------------------------------------------------------------------------
// igmp_report_scheduler: IGMPv2 host membership report timer
// Keeps the joined group table and its report countdowns, and issues reports.
//
//   Channel  Handshake                Payload
//   command  start, busy              cmd   (igr_pkg::in_word_t)
//   result   res_strobe (one cycle)   res   (igr_pkg::out_word_t)
//   config   APB psel/penable/pwrite  paddr, pwdata, prdata, pready
//
// A message that is not a general query is answered in the cycle after start is taken.
// Ticks, general queries, joins and leaves walk the table memory slot by slot
// (read, then modify and write back); a join or leave stops at its matching
// slot, a tick after 16 reports.
// Reset clears the valid bits but not the table memory, which needs no clearing pass.
// busy stays high during a walk; results cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module igmp_report_scheduler #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  igr_pkg::in_word_t  cmd,
	output logic               busy,
	output logic               res_strobe,
	output igr_pkg::out_word_t res,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic          rand_en_q;
	logic [31:0]   seed_q;
	logic          wr;
	igr_pkg::cfg_t cfg;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rand_en_q <= 1'b1;
			seed_q    <= 32'd1;
		end else if (wr) begin
			if (paddr[2] == igr_pkg::REG_RAND_EN) begin
				rand_en_q <= pwdata[0];
			end else begin
				seed_q <= pwdata;
			end
		end
	end

	// Register read back.
	assign prdata = (paddr[2] == igr_pkg::REG_SEED) ? seed_q : {31'd0, rand_en_q};

	assign cfg = '{rand_en_q, wr && (paddr[2] == igr_pkg::REG_SEED), pwdata};

	igr_walker #(
		.DEPTH (TABLE_DEPTH)
	) u_walker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.start      (start),
		.cmd        (cmd),
		.busy       (busy),
		.res_strobe (res_strobe),
		.res        (res)
	);

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the IGMP report scheduler
// Drives joins, leaves, ticks and received messages through the command port,
// predicts every status word and report from a model of the group table held
// in a scoreboard class, and writes both registers between phases.
// ----------------------------------------------------------------------------
module tb;
	import igr_pkg::*;

	localparam int DEPTH       = 16;
	localparam int WALK_CYCLES = 2 * DEPTH + 8;
	localparam int CYCLE_LIMIT = 400000;

	logic        clk;
	logic        arst_n;
	logic        start;
	in_word_t    cmd;
	logic        busy;
	logic        res_strobe;
	out_word_t   res;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int mismatches = 0;
	int cycles     = 0;
	logic [31:0] group_pool[24];

	igmp_report_scheduler #(.TABLE_DEPTH(DEPTH)) uut (
		.clk(clk), .arst_n(arst_n), .start(start), .cmd(cmd), .busy(busy),
		.res_strobe(res_strobe), .res(res), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
		.pready(pready)
	);

	// Prints one line per mismatch and keeps count.
	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("mismatch at %0t: %s", $realtime, msg);
	endtask

	// Model of the group table and the words it is expected to produce.
	class membership_scoreboard;
		bit          rand_en;
		logic [31:0] lfsr;
		bit          valid[DEPTH];
		logic [31:0] grp[DEPTH];
		logic [7:0]  countdown[DEPTH];
		logic [7:0]  sockets[DEPTH];
		out_word_t   expected_words[$];

		function new();
			rand_en = 1'b1;
			lfsr    = 32'd1;
			foreach (valid[i]) valid[i] = 1'b0;
		endfunction

		function void write_reg(logic [2:0] addr, logic [31:0] data);
			if (addr[2] == REG_SEED)
				lfsr = (data != 0) ? data : 32'd1;
			else
				rand_en = data[0];
		endfunction

		// Galois LFSR, shifting right.
		function logic [31:0] next_random();
			logic lsb;
			lsb  = lfsr[0];
			lfsr = lfsr >> 1;
			if (lsb)
				lfsr = lfsr ^ LFSR_TAPS;
			return lfsr;
		endfunction

		function void push_status(logic [2:0] st);
			out_word_t w;
			w = '0;
			w.status = st;
			w.last   = 1'b1;
			expected_words.push_back(w);
		endfunction

		// Reschedules idle or late entries after a general query.
		function void general_query(logic [7:0] mrt);
			logic [31:0] m;
			logic [31:0] mask;
			logic [31:0] r;
			logic [31:0] counter;
			m       = ((mrt < 2) ? 32'd2 : {24'd0, mrt}) - 1;
			mask    = m - 1;
			mask    = mask | (mask >> 1);
			mask    = mask | (mask >> 2);
			mask    = mask | (mask >> 4);
			if (mask == 0)
				mask = 1;
			counter = 1;
			for (int i = 0; i < DEPTH; i++) begin
				if (valid[i] && (countdown[i] == 0 || countdown[i] >= mrt)) begin
					if (rand_en) begin
						r = next_random() & mask;
						if (r == 0)
							r = 1;
						while (r > m)
							r = r - m;
					end else begin
						r = counter;
						counter++;
						if (counter > m)
							counter = 1;
					end
					countdown[i] = r[7:0];
				end
			end
		endfunction

		function void note_command(in_word_t c);
			int        slot;
			int        n;
			out_word_t w;
			logic [31:0] r;
			slot = -1;
			case (c.mode)
				MODE_TICK: begin
					n = 0;
					for (int i = 0; i < DEPTH && n < MAX_RESULTS; i++) begin
						if (valid[i] && countdown[i] > 0) begin
							countdown[i]--;
							if (countdown[i] == 0) begin
								w = '0;
								w.is_report    = 1'b1;
								w.report_group = grp[i];
								w.report_type  = TYPE_REPORT_V2;
								w.status       = ST_OTHER;
								expected_words.push_back(w);
								n++;
							end
						end
					end
					if (n > 0)
						expected_words[expected_words.size() - 1].last = 1'b1;
				end
				MODE_MSG: begin
					if (c.msg_type == TYPE_QUERY) begin
						if (c.group_addr == 0)
							general_query(c.max_resp_time);
						push_status(ST_QUERY);
					end else begin
						push_status(ST_OTHER);
					end
				end
				MODE_JOIN: begin
					for (int i = 0; i < DEPTH; i++)
						if (slot < 0 && valid[i] && grp[i] == c.group_addr)
							slot = i;
					if (slot >= 0) begin
						if (sockets[slot] < 8'd255)
							sockets[slot]++;
						push_status(ST_DUP);
					end else begin
						for (int i = 0; i < DEPTH; i++)
							if (slot < 0 && !valid[i])
								slot = i;
						if (slot < 0) begin
							push_status(ST_FULL);
						end else begin
							r = rand_en ? next_random() : slot;
							valid[slot]     = 1'b1;
							grp[slot]       = c.group_addr;
							sockets[slot]   = 8'd1;
							countdown[slot] = 8'd2 + {5'd0, r[2:0] & JOIN_MASK};
							push_status(ST_ADDED);
						end
					end
				end
				default: begin
					for (int i = 0; i < DEPTH; i++)
						if (slot < 0 && valid[i] && grp[i] == c.group_addr)
							slot = i;
					if (slot < 0) begin
						push_status(ST_NOTFND);
					end else begin
						if (sockets[slot] > 0)
							sockets[slot]--;
						if (sockets[slot] == 0) begin
							valid[slot] = 1'b0;
							push_status(ST_REMOVED);
						end else begin
							push_status(ST_DECR);
						end
					end
				end
			endcase
		endfunction

		task check_word(out_word_t r);
			out_word_t e;
			if (expected_words.size() == 0) begin
				report_mismatch($sformatf("unexpected word %h", r));
				return;
			end
			e = expected_words.pop_front();
			if (r.is_report !== e.is_report)
				report_mismatch($sformatf("is_report %b, want %b", r.is_report, e.is_report));
			if (r.report_group !== e.report_group)
				report_mismatch($sformatf("report_group %h, want %h",
					r.report_group, e.report_group));
			if (r.report_type !== e.report_type)
				report_mismatch($sformatf("report_type %h, want %h",
					r.report_type, e.report_type));
			if (r.status !== e.status)
				report_mismatch($sformatf("status %0d, want %0d", r.status, e.status));
			if (r.last !== e.last)
				report_mismatch($sformatf("last %b, want %b", r.last, e.last));
		endtask
	endclass

	membership_scoreboard table_model = new();

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watches accepted commands, result words and register writes.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n) begin
			if (start && !busy)
				table_model.note_command(cmd);
			if (res_strobe)
				table_model.check_word(res);
			if (psel && penable && pwrite && pready)
				table_model.write_reg(paddr, pwdata);
		end
	end

	// Ends the run if it hangs.
	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Offers one command word and waits until it is taken.
	task automatic send_command(input in_word_t c);
		start <= 1'b1;
		cmd   <= c;
		do
			@(posedge clk);
		while (busy);
	endtask

	// Short gaps mostly, a long one now and then, none in some stretches.
	task automatic sender_gap(input bit no_gaps);
		int n;
		n = no_gaps ? 0 : (($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
			: $urandom_range(0, 2));
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic issue(input logic [1:0] mode, input logic [7:0] mtype,
		input logic [7:0] mrt, input logic [31:0] g);
		in_word_t c;
		c.mode          = mode;
		c.msg_type      = mtype;
		c.max_resp_time = mrt;
		c.group_addr    = g;
		send_command(c);
		sender_gap(1'b0);
	endtask

	// Waits for every expected word and for any walk still running.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (table_model.expected_words.size() != 0 || busy)
			@(posedge clk);
		repeat (WALK_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [2:0] addr, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	function automatic in_word_t random_command();
		in_word_t c;
		int sel;
		c.msg_type      = 8'($urandom_range(0, 255));
		c.max_resp_time = 8'($urandom_range(0, 255));
		c.group_addr    = ($urandom_range(0, 7) == 0) ? $urandom()
			: group_pool[$urandom_range(0, 23)];
		sel = $urandom_range(0, 99);
		if (sel < 35) begin
			c.mode = MODE_TICK;
		end else if (sel < 60) begin
			c.mode = MODE_JOIN;
		end else if (sel < 78) begin
			c.mode = MODE_LEAVE;
		end else begin
			c.mode = MODE_MSG;
			// Most messages are general queries, most of those with a short response time.
			if (sel < 92) begin
				c.msg_type   = TYPE_QUERY;
				c.group_addr = (sel < 90) ? 32'd0 : c.group_addr;
				if (sel < 86)
					c.max_resp_time = 8'($urandom_range(0, 12));
			end
		end
		return c;
	endfunction

	initial begin
		logic [31:0] seeds[4];
		arst_n  = 1'b0;
		start   = 1'b0;
		cmd     = '0;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;
		foreach (group_pool[i])
			group_pool[i] = {8'hE0, 24'(i * 32'h0105_03)};
		group_pool[0] = 32'h0000_0000;
		group_pool[1] = 32'hFFFF_FFFF;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: extremes of the fields and each special case.
		issue(MODE_JOIN, 8'h00, 8'h00, 32'h0000_0000);
		issue(MODE_JOIN, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
		issue(MODE_JOIN, 8'h00, 8'h00, 32'hFFFF_FFFF);
		issue(MODE_LEAVE, 8'h00, 8'h00, 32'hFFFF_FFFF);
		issue(MODE_LEAVE, 8'h00, 8'h00, 32'h1234_5678);
		issue(MODE_MSG, TYPE_REPORT_V2, 8'h00, 32'hE000_0001);
		issue(MODE_MSG, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
		issue(MODE_MSG, TYPE_QUERY, 8'h0A, 32'hE000_0001);
		issue(MODE_MSG, TYPE_QUERY, 8'h00, 32'h0000_0000);
		issue(MODE_MSG, TYPE_QUERY, 8'h01, 32'h0000_0000);
		issue(MODE_MSG, TYPE_QUERY, 8'h02, 32'h0000_0000);
		issue(MODE_MSG, TYPE_QUERY, 8'hFF, 32'h0000_0000);
		repeat (3)
			issue(MODE_TICK, 8'h00, 8'h00, 32'h0);
		issue(MODE_LEAVE, 8'h00, 8'h00, 32'h0000_0000);
		issue(MODE_LEAVE, 8'h00, 8'h00, 32'hFFFF_FFFF);
		issue(MODE_TICK, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
		drain();

		// Phases under several register settings, extremes among them.
		seeds[0] = 32'hFFFF_FFFF;
		seeds[1] = 32'h0000_0001;
		seeds[2] = $urandom() | 32'd1;
		seeds[3] = 32'h8000_0000;
		for (int ph = 0; ph < 6; ph++) begin
			write_register({REG_RAND_EN, 2'b00}, {31'd0, 1'(ph % 3 != 1)});
			write_register({REG_SEED, 2'b00}, seeds[ph % 4]);
			// Fill the table so that a full join is seen.
			if (ph == 0) begin
				for (int i = 0; i < DEPTH + 1; i++)
					issue(MODE_JOIN, 8'h00, 8'h00, group_pool[i + 2]);
			end
			for (int k = 0; k < 85; k++) begin
				send_command(random_command());
				sender_gap(ph == 2);
			end
			drain();
		end

		if (table_model.expected_words.size() != 0)
			report_mismatch($sformatf("%0d words never arrived",
				table_model.expected_words.size()));
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

### filelist.f
rtl/igr_pkg.sv
rtl/igr_ram.sv
rtl/igr_walker.sv
rtl/igmp_report_scheduler.sv
tb/sv/tb.sv
